// ===== sv/rgbhsv_pkg.sv =====
// Shared constants for the RGB to HSV/HSL converter.
`default_nettype none
package rgbhsv_pkg;
    localparam int unsigned HUE_W       = 15;
    localparam int unsigned SAT_W       = 16;
    localparam int unsigned QBITS       = 17;
    localparam int unsigned SAT_ONE     = 65535;
    localparam int unsigned HUE_SEXTANT = 3840;
    localparam int unsigned HUE_CIRCLE  = 23040;
endpackage
`default_nettype wire

// ===== sv/rgb_to_hsv_hsl.sv =====
// RGB to HSV/HSL conversion pipeline: hue, saturations, value and lightness sum.
// Pipeline from pixel transaction to result: 2 setup stages,
// 17 restoring-division stages, 1 rounding stage.
// Throughput: one pixel per cycle while the result is not stalled; the three
// dividers each retire one quotient bit per stage, which sets the depth.
// Each stage holds while its successor is full and stalled, so bubbles collapse.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
module rgb_to_hsv_hsl
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    pix_valid,
    output logic                         pix_stall,
    input  wire logic [CHANNEL_BITS-1:0] red,
    input  wire logic [CHANNEL_BITS-1:0] green,
    input  wire logic [CHANNEL_BITS-1:0] blue,
    output logic                         res_valid,
    input  wire logic                    res_stall,
    output logic [HUE_W-1:0]             hue,
    output logic [SAT_W-1:0]             sat_hsv,
    output logic [CHANNEL_BITS-1:0]      value,
    output logic [SAT_W-1:0]             sat_hsl,
    output logic [CHANNEL_BITS:0]        light_sum,
    output logic                         is_grey
);
    localparam int C  = CHANNEL_BITS;
    localparam int NW = C + QBITS;
    localparam int PW = C + 4;
    localparam int HW = C + 20;

    typedef struct packed {
        logic [C:0]       rem;
        logic [QBITS-1:0] sh;
        logic [C-1:0]     den;
    } div_t;

    typedef struct packed {
        div_t       hd;
        div_t       sv;
        div_t       sl;
        logic [C-1:0] value;
        logic [C:0]   sum;
        logic         grey;
    } pipe_t;

    typedef struct packed {
        logic [C-1:0]         mx;
        logic [C-1:0]         delta;
        logic [C:0]           sum;
        logic [C-1:0]         hsl_den;
        logic signed [PW-1:0] hpre;
        logic                 grey;
    } front_t;

    function automatic div_t div_step(input div_t x);
        logic [C+1:0] t;
        logic [C+1:0] diff;
        div_t         y;
        t    = {x.rem, x.sh[QBITS-1]};
        diff = t - {2'b00, x.den};
        y    = x;
        if (!diff[C+1])
        begin
            y.rem = diff[C:0];
            y.sh  = {x.sh[QBITS-2:0], 1'b1};
        end
        else
        begin
            y.rem = t[C:0];
            y.sh  = {x.sh[QBITS-2:0], 1'b0};
        end
        return y;
    endfunction

    function automatic div_t div_init(input logic [NW-1:0] num, input logic [C-1:0] den);
        div_t y;
        y.rem = {1'b0, num[NW-1:QBITS]};
        y.sh  = num[QBITS-1:0];
        y.den = den;
        return y;
    endfunction

    front_t a_reg, a_next;
    pipe_t  b_reg, b_next;
    pipe_t  d_reg [QBITS];
    logic   a_v_reg, b_v_reg, o_v_reg;
    logic   d_v_reg [QBITS];
    logic   go_a, go_b, go_o;
    logic   go_d [QBITS];

    logic [HUE_W-1:0]  hue_reg, hue_next;
    logic [SAT_W-1:0]  shsv_reg, shsv_next, shsl_reg, shsl_next;
    logic [C-1:0]      value_reg;
    logic [C:0]        sum_reg;
    logic              grey_reg;

    // stall chain
    assign go_o = !o_v_reg || !res_stall;
    assign go_d[QBITS-1] = !d_v_reg[QBITS-1] || go_o;
    for (genvar k = 0; k < QBITS - 1; k++)
    begin : g_go
        assign go_d[k] = !d_v_reg[k] || go_d[k+1];
    end
    assign go_b = !b_v_reg || go_d[0];
    assign go_a = !a_v_reg || go_b;
    assign pix_stall = !go_a;

    // front: max, min, hue numerator before scaling
    always_comb
    begin
        logic [C-1:0]        mx, mn;
        logic signed [PW-1:0] r, g, b, dl;
        mx = (red > green) ? red : green;
        if (mx < blue)
            mx = blue;
        mn = (red < green) ? red : green;
        if (mn > blue)
            mn = blue;
        r  = PW'(red);
        g  = PW'(green);
        b  = PW'(blue);
        dl = PW'(mx - mn);
        a_next.mx    = mx;
        a_next.delta = mx - mn;
        a_next.sum   = {1'b0, mx} + {1'b0, mn};
        a_next.grey  = (mx == mn);
        if (a_next.sum <= {1'b0, {C{1'b1}}})
            a_next.hsl_den = a_next.sum[C-1:0];
        else
            a_next.hsl_den = {C{1'b1}} - mx + {C{1'b1}} - mn;
        if (red == mx)
            a_next.hpre = g - b;
        else if (green == mx)
            a_next.hpre = PW'(2 * dl + b - r);
        else
            a_next.hpre = PW'(4 * dl + r - g);
    end

    // scaled numerators, doubled for round-to-nearest
    always_comb
    begin
        logic signed [HW-1:0] hn;
        logic [NW-1:0]        sn;
        hn = HW'(a_reg.hpre) * HW'(2 * HUE_SEXTANT);
        if (a_reg.hpre < 0)
            hn = hn + HW'(a_reg.delta) * HW'(2 * HUE_CIRCLE);
        sn = NW'(a_reg.delta) * NW'(2 * SAT_ONE);
        b_next.hd    = div_init(hn[NW-1:0], a_reg.delta);
        b_next.sv    = div_init(sn, a_reg.mx);
        b_next.sl    = div_init(sn, a_reg.hsl_den);
        b_next.value = a_reg.mx;
        b_next.sum   = a_reg.sum;
        b_next.grey  = a_reg.grey;
    end

    // rounding and wrap
    always_comb
    begin
        pipe_t        p;
        logic [QBITS:0] hr, vr, lr;
        logic [QBITS-1:0] h;
        p  = d_reg[QBITS-1];
        hr = {1'b0, p.hd.sh} + 1'b1;
        vr = {1'b0, p.sv.sh} + 1'b1;
        lr = {1'b0, p.sl.sh} + 1'b1;
        h  = hr[QBITS:1];
        if (h >= QBITS'(HUE_CIRCLE))
            h = h - QBITS'(HUE_CIRCLE);
        hue_next  = p.grey ? '0 : h[HUE_W-1:0];
        shsv_next = p.grey ? '0 : vr[SAT_W:1];
        shsl_next = p.grey ? '0 : lr[SAT_W:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
            for (int i = 0; i < QBITS; i++)
                d_v_reg[i] <= 1'b0;
        end
        else
        begin
            if (go_a)
                a_v_reg <= pix_valid;
            if (go_b)
                b_v_reg <= a_v_reg;
            if (go_d[0])
                d_v_reg[0] <= b_v_reg;
            for (int i = 1; i < QBITS; i++)
                if (go_d[i])
                    d_v_reg[i] <= d_v_reg[i-1];
            if (go_o)
                o_v_reg <= d_v_reg[QBITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_a)
            a_reg <= a_next;
        if (go_b)
            b_reg <= b_next;
        if (go_d[0])
        begin
            d_reg[0].hd <= div_step(b_reg.hd);
            d_reg[0].sv <= div_step(b_reg.sv);
            d_reg[0].sl <= div_step(b_reg.sl);
            d_reg[0].value <= b_reg.value;
            d_reg[0].sum   <= b_reg.sum;
            d_reg[0].grey  <= b_reg.grey;
        end
        for (int i = 1; i < QBITS; i++)
            if (go_d[i])
            begin
                d_reg[i].hd <= div_step(d_reg[i-1].hd);
                d_reg[i].sv <= div_step(d_reg[i-1].sv);
                d_reg[i].sl <= div_step(d_reg[i-1].sl);
                d_reg[i].value <= d_reg[i-1].value;
                d_reg[i].sum   <= d_reg[i-1].sum;
                d_reg[i].grey  <= d_reg[i-1].grey;
            end
        if (go_o)
        begin
            hue_reg   <= hue_next;
            shsv_reg  <= shsv_next;
            shsl_reg  <= shsl_next;
            value_reg <= d_reg[QBITS-1].value;
            sum_reg   <= d_reg[QBITS-1].sum;
            grey_reg  <= d_reg[QBITS-1].grey;
        end
    end

    assign res_valid = o_v_reg;
    assign hue       = hue_reg;
    assign sat_hsv   = shsv_reg;
    assign sat_hsl   = shsl_reg;
    assign value     = value_reg;
    assign light_sum = sum_reg;
    assign is_grey   = grey_reg;
endmodule
`default_nettype wire

// ===== sv/rgbhsv_checker.sv =====
// Port-level checks for the RGB to HSV/HSL converter, with bind.
`default_nettype none
module rgbhsv_checker
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    res_valid,
    input wire logic                    res_stall,
    input wire logic [HUE_W-1:0]        hue,
    input wire logic [SAT_W-1:0]        sat_hsv,
    input wire logic [CHANNEL_BITS-1:0] value,
    input wire logic [SAT_W-1:0]        sat_hsl,
    input wire logic [CHANNEL_BITS:0]   light_sum,
    input wire logic                    is_grey
);
    a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_grey |-> hue == '0 && sat_hsv == '0 && sat_hsl == '0)
        else $error("grey result with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> hue < HUE_W'(HUE_CIRCLE))
        else $error("hue out of range");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> light_sum <= {value, 1'b0}
            && (is_grey == (light_sum == {value, 1'b0})))
        else $error("lightness sum inconsistent with value");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(hue) && $stable(sat_hsv))
        else $error("stalled transaction changed");
endmodule

bind rgb_to_hsv_hsl rgbhsv_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_rgbhsv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .hue       (hue),
    .sat_hsv   (sat_hsv),
    .value     (value),
    .sat_hsl   (sat_hsl),
    .light_sum (light_sum),
    .is_grey   (is_grey)
);
`default_nettype wire
